@@ design/slir_pkg.sv @@
`default_nettype none

package slir_pkg;

  // Default sizing of the sample log and of the interpolation fraction.
  localparam int unsigned LogDepthDef = 1024;
  localparam int unsigned FracBitsDef = 16;

  // Request modes.
  localparam logic [1:0] MODE_REC = 2'd0;
  localparam logic [1:0] MODE_CLR = 2'd1;
  localparam logic [1:0] MODE_QRY = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ design/sample_log_interpolating_resampler.sv @@
// Sample log with piecewise linear interpolation. A request is taken when start_i is high
// and busy_o is low; each request gives exactly one result, shown on the result ports for
// a single cycle with valid_o high, and the receiver cannot hold it off. Record, clear,
// unused-mode requests and a query on an empty log finish at once: their result appears
// in the next cycle and busy_o stays low. A query on a non-empty log runs on one sequencer
// around the single log memory read port: each binary-search probe passes S_PROBE and
// S_CMP (at most ceil(log2(n+1)) probes for n held samples) and a last S_PROBE ends the
// search, S_RDF, S_RDS and S_CAPS fetch the two neighbours, then come restoring division
// for the factor, a multiply and a final add. A query's result shows in the cycle in which
// busy_o falls. The division is skipped when the query lies outside the neighbours, and
// the query ends after the fetch when the neighbour times are equal or reversed. The log
// memory needs no clearing pass after reset.

`default_nettype none

module sample_log_interpolating_resampler #(
  parameter int unsigned LOG_DEPTH = slir_pkg::LogDepthDef,
  parameter int unsigned FRAC_BITS = slir_pkg::FracBitsDef,
  localparam int unsigned CntW     = $clog2(LOG_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          mode_i,
  input  logic [31:0]         site_i,
  input  logic signed [31:0]  sample_i,
  input  logic                last_query_i,
  output logic                valid_o,
  output logic signed [31:0]  result_o,
  output logic [1:0]          status_o,
  output logic [CntW-1:0]     held_o,
  output logic                batch_end_o
);

  localparam int unsigned AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned StepW = $clog2(FRAC_BITS);
  localparam int unsigned ProdW = 35 + FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROBE = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_RDF   = 4'd3;
  localparam logic [3:0] S_RDS   = 4'd4;
  localparam logic [3:0] S_CAPS  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]             state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0]            qry_q, qry_d;
  logic [31:0]            tf_q, tf_d, vf_q, vf_d, vs_q, vs_d;
  logic [31:0]            rem_q, rem_d, den_q, den_d;
  logic [FRAC_BITS:0]     k_q, k_d;
  logic [StepW-1:0]       step_q, step_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                   last_q, last_d;

  logic                   valid_q, valid_d;
  logic [31:0]            result_q, result_d;
  logic [1:0]             status_q, status_d;
  logic [CntW-1:0]        held_q, held_d;
  logic                   batch_q, batch_d;

  logic [63:0]            mem [LOG_DEPTH];
  logic [63:0]            rd_q;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;

  logic [CntW:0]          mid_sum;
  logic [CntW-1:0]        mid_w, fi_w, si_w;
  logic [32:0]            rem_sh, rem_sub;
  logic                   rem_ge;
  logic signed [32:0]     diff_w;
  logic signed [FRAC_BITS+1:0] k_s;
  logic signed [ProdW-1:0] prod_w, shr_w;
  logic [31:0]            ts_rd, vs_rd;

  // Binary-search midpoint and the clamped neighbour indexes.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = mid_sum[CntW:1];
  assign fi_w    = (lo_q == '0) ? '0 : lo_q - 1'b1;
  assign si_w    = (lo_q < count_q) ? lo_q : count_q - 1'b1;

  // Restoring division step: shift the remainder and try to subtract the divisor.
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Weighted difference of the two neighbour values, floor-shifted back to Q16.16.
  assign diff_w  = $signed({vf_q[31], vf_q}) - $signed({vs_q[31], vs_q});
  assign k_s     = $signed({1'b0, k_q});
  assign prod_w  = diff_w * k_s;
  assign shr_w   = prod_q >>> FRAC_BITS;

  assign ts_rd   = rd_q[63:32];
  assign vs_rd   = rd_q[31:0];

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    qry_d    = qry_q;
    tf_d     = tf_q;
    vf_d     = vf_q;
    vs_d     = vs_q;
    rem_d    = rem_q;
    den_d    = den_q;
    k_d      = k_q;
    step_d   = step_q;
    prod_d   = prod_q;
    last_d   = last_q;
    valid_d  = 1'b0;
    result_d = result_q;
    status_d = status_q;
    held_d   = held_q;
    batch_d  = batch_q;
    mem_we   = 1'b0;
    rd_addr  = mid_w[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          last_d   = last_query_i;
          batch_d  = last_query_i;
          result_d = '0;
          status_d = slir_pkg::ST_OK;
          held_d   = count_q;
          unique case (mode_i)
            slir_pkg::MODE_REC: begin
              valid_d = 1'b1;
              if (count_q >= CntW'(LOG_DEPTH)) begin
                status_d = slir_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
                held_d  = count_q + 1'b1;
              end
            end
            slir_pkg::MODE_CLR: begin
              valid_d = 1'b1;
              count_d = '0;
              held_d  = '0;
            end
            slir_pkg::MODE_QRY: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = slir_pkg::ST_EMPTY;
              end else begin
                qry_d   = site_i;
                lo_d    = '0;
                hi_d    = count_q;
                state_d = S_PROBE;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_w;
          rd_addr = mid_w[AW-1:0];
          state_d = S_CMP;
        end else begin
          state_d = S_RDF;
        end
      end
      S_CMP: begin
        if (ts_rd < qry_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_PROBE;
      end
      S_RDF: begin
        rd_addr = fi_w[AW-1:0];
        state_d = S_RDS;
      end
      S_RDS: begin
        rd_addr = si_w[AW-1:0];
        tf_d    = ts_rd;
        vf_d    = vs_rd;
        state_d = S_CAPS;
      end
      S_CAPS: begin
        vs_d = vs_rd;
        if (ts_rd <= tf_q) begin
          // Equal or reversed neighbour times: take the earlier value.
          valid_d  = 1'b1;
          result_d = vf_q;
          status_d = slir_pkg::ST_OK;
          held_d   = count_q;
          batch_d  = last_q;
          state_d  = S_IDLE;
        end else if (qry_q >= ts_rd) begin
          k_d     = '0;
          state_d = S_MUL;
        end else if (qry_q <= tf_q) begin
          k_d     = {1'b1, {FRAC_BITS{1'b0}}};
          state_d = S_MUL;
        end else begin
          rem_d   = ts_rd - qry_q;
          den_d   = ts_rd - tf_q;
          k_d     = '0;
          step_d  = StepW'(FRAC_BITS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        k_d   = {k_q[FRAC_BITS-1:0], rem_ge};
        if (step_q == '0) begin
          state_d = S_MUL;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_MUL: begin
        prod_d  = prod_w;
        state_d = S_FIN;
      end
      S_FIN: begin
        valid_d  = 1'b1;
        result_d = vs_q + shr_w[31:0];
        status_d = slir_pkg::ST_OK;
        held_d   = count_q;
        batch_d  = last_q;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Log memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= {site_i, sample_i};
    end
    rd_q <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    qry_q    <= qry_d;
    tf_q     <= tf_d;
    vf_q     <= vf_d;
    vs_q     <= vs_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    k_q      <= k_d;
    step_q   <= step_d;
    prod_q   <= prod_d;
    last_q   <= last_d;
    result_q <= result_d;
    status_q <= status_d;
    held_q   <= held_d;
    batch_q  <= batch_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;
  assign held_o      = held_q;
  assign batch_end_o = batch_q;

endmodule

`default_nettype wire

@@ design/slir_checker.sv @@
`default_nettype none

module slir_checker #(
  parameter int unsigned LOG_DEPTH = slir_pkg::LogDepthDef,
  localparam int unsigned CntW     = $clog2(LOG_DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [1:0]         mode_i,
  input logic               last_query_i,
  input logic               valid_o,
  input logic signed [31:0] result_o,
  input logic [1:0]         status_o,
  input logic [CntW-1:0]    held_o,
  input logic               batch_end_o
);

  // A request other than a query is answered in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i != slir_pkg::MODE_QRY) |=> valid_o && !busy_o)
    else $error("immediate request gave no result");

  // A clear empties the log and reports nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i == slir_pkg::MODE_CLR) |=>
      (held_o == '0) && (status_o == slir_pkg::ST_OK) && (result_o == '0))
    else $error("clear result wrong");

  // An empty-log report comes only with an empty log and a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == slir_pkg::ST_EMPTY) |-> (held_o == '0) && (result_o == '0))
    else $error("empty status with samples held");

  // A query ends exactly when its result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o)
    else $error("query finished without a result");

  // The batch mark of a record is the one given with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i == slir_pkg::MODE_REC) |=>
      (batch_end_o == $past(last_query_i)))
    else $error("batch mark lost");

endmodule

bind sample_log_interpolating_resampler slir_checker #(.LOG_DEPTH(LOG_DEPTH)) u_slir_checker (.*);

`default_nettype wire

@@ test/sample_log_interpolating_resampler_test.sv @@
`timescale 1ns / 1ps

module sample_log_interpolating_resampler_test;

  localparam int unsigned LOG_DEPTH    = slir_pkg::LogDepthDef;
  localparam int unsigned FRAC_BITS    = slir_pkg::FracBitsDef;
  localparam int unsigned CNT_W        = $clog2(LOG_DEPTH + 1);
  localparam int          RANDOM_ITEMS = 160;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          SETTLE_WAIT  = 64;
  localparam int          REPORT_MAX   = 10;

  // The fourth request mode is unused by the block and must change nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // One result as seen on the result ports.
  typedef struct packed {
    logic [31:0]      value;
    logic [1:0]       status;
    logic [CNT_W-1:0] held;
    logic             batch_end;
  } reading_t;

  // One request, with an optional typed-in result that replaces the prediction.
  typedef struct {
    logic [1:0]  mode;
    logic [31:0] site;
    logic [31:0] sample;
    logic        last;
    bit          pinned;
    reading_t    want;
  } stim_row_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [1:0]       mode_i       = slir_pkg::MODE_REC;
  logic [31:0]      site_i       = '0;
  logic [31:0]      sample_i     = '0;
  logic             last_query_i = 1'b0;
  logic             busy_o;
  logic             valid_o;
  logic [31:0]      result_o;
  logic [1:0]       status_o;
  logic [CNT_W-1:0] held_o;
  logic             batch_end_o;

  // Typed-in result travelling with the request that is on the ports.
  bit       pin_valid = 1'b0;
  reading_t pin_want  = '0;

  reading_t    awaited_q[$];
  stim_row_t   directed_rows[$];
  logic [31:0] batch_times[$];
  int          n_mismatch = 0;
  int          n_issued   = 0;
  int          n_cycles   = 0;
  int          gap_pct    = 0;

  // Own copy of the sample log.
  logic [31:0] lg_time [LOG_DEPTH];
  logic [31:0] lg_value[LOG_DEPTH];
  int unsigned lg_count = 0;

  sample_log_interpolating_resampler u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .site_i       (site_i),
    .sample_i     (sample_i),
    .last_query_i (last_query_i),
    .valid_o      (valid_o),
    .result_o     (result_o),
    .status_o     (status_o),
    .held_o       (held_o),
    .batch_end_o  (batch_end_o)
  );

  always #2 clk_i = ~clk_i;

  // Index of the first logged time at or above the query time.
  function automatic int unsigned first_not_below(logic [31:0] q);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = lg_count;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (lg_time[mid] < q) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // Linear interpolation between the clamped neighbours around the query time.
  function automatic logic [31:0] interpolate_at(logic [31:0] q);
    int unsigned     idx;
    int unsigned     fi;
    int unsigned     si;
    longint unsigned tf;
    longint unsigned ts;
    longint unsigned k;
    longint unsigned unit;
    longint          vf;
    longint          vs;
    longint          prod;
    longint          sum;
    idx  = first_not_below(q);
    fi   = (idx > 0) ? idx - 1 : 0;
    si   = (idx < lg_count) ? idx : lg_count - 1;
    tf   = lg_time[fi];
    ts   = lg_time[si];
    vf   = $signed(lg_value[fi]);
    vs   = $signed(lg_value[si]);
    unit = 64'd1 << FRAC_BITS;
    if (ts <= tf) begin
      return lg_value[fi];
    end
    if (q >= ts) begin
      k = 0;
    end else if (q <= tf) begin
      k = unit;
    end else begin
      k = ((ts - q) << FRAC_BITS) / (ts - tf);
    end
    if (k > unit) begin
      k = unit;
    end
    // The arithmetic shift rounds toward minus infinity.
    prod = (vf - vs) * longint'(k);
    sum  = vs + (prod >>> FRAC_BITS);
    return sum[31:0];
  endfunction

  // Applies one request to the log copy and works out the result it gives.
  function automatic reading_t apply_request(logic [1:0] mode, logic [31:0] site,
                                             logic [31:0] sample, logic last);
    reading_t r;
    r.value     = '0;
    r.status    = slir_pkg::ST_OK;
    r.batch_end = last;
    case (mode)
      slir_pkg::MODE_REC: begin
        if (lg_count >= LOG_DEPTH) begin
          r.status = slir_pkg::ST_FULL;
        end else begin
          lg_time[lg_count]  = site;
          lg_value[lg_count] = sample;
          lg_count++;
        end
      end
      slir_pkg::MODE_CLR: begin
        lg_count = 0;
      end
      slir_pkg::MODE_QRY: begin
        if (lg_count == 0) begin
          r.status = slir_pkg::ST_EMPTY;
        end else begin
          r.value = interpolate_at(site);
        end
      end
      default: begin
      end
    endcase
    r.held = lg_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t plain_row(logic [1:0] mode, logic [31:0] site,
                                          logic [31:0] sample, logic last);
    stim_row_t row;
    row.mode   = mode;
    row.site   = site;
    row.sample = sample;
    row.last   = last;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic [31:0] site,
                         input logic [31:0] sample, input logic last, input bit pinned,
                         input logic [31:0] value, input logic [1:0] status, input int held);
    stim_row_t row;
    row                = plain_row(mode, site, sample, last);
    row.pinned         = pinned;
    row.want.value     = value;
    row.want.status    = status;
    row.want.held      = held[CNT_W-1:0];
    row.want.batch_end = last;
    directed_rows.push_back(row);
  endtask

  // Sample values: mostly random, some small, some at the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Query times around the samples of the current batch.
  function automatic logic [31:0] pick_query_site();
    logic [31:0]     lo_t;
    logic [31:0]     hi_t;
    logic [31:0]     probe;
    longint unsigned span;
    if (batch_times.size() == 0) begin
      return $urandom;
    end
    lo_t  = batch_times[0];
    hi_t  = batch_times[$];
    probe = batch_times[$urandom_range(0, batch_times.size() - 1)];
    case ($urandom_range(0, 6))
      0: return probe;
      1: return probe + 32'd1;
      2: return (lo_t == 0) ? 32'd0 : $urandom_range(0, lo_t - 1);
      3: return (hi_t > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF : hi_t + $urandom_range(1, 16);
      4: return $urandom;
      default: begin
        if (hi_t <= lo_t) begin
          return probe;
        end
        span = longint'(hi_t - lo_t) + 1;
        return lo_t + 32'($urandom % span);
      end
    endcase
  endfunction

  // Presents one request at a falling edge and holds it until it is taken.
  task automatic send(input stim_row_t row);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < gap_pct) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    mode_i       <= row.mode;
    site_i       <= row.site;
    sample_i     <= row.sample;
    last_query_i <= row.last;
    pin_valid    <= row.pinned;
    pin_want     <= row.want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    n_issued++;
    @(negedge clk_i);
  endtask

  // Holds requests back until every outstanding result has come.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (awaited_q.size() != 0) @(negedge clk_i);
  endtask

  // Result checking and prediction of taken requests.
  always @(posedge clk_i) begin : result_monitor
    reading_t seen;
    reading_t want;
    reading_t fresh;
    if (rst_ni) begin
      // A result finishing at this edge belongs to an older request, so it is compared first.
      if (valid_o) begin
        seen.value     = result_o;
        seen.status    = status_o;
        seen.held      = held_o;
        seen.batch_end = batch_end_o;
        if (awaited_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_MAX) begin
            $display("%0t: result with no request outstanding: result=%h status=%0d held=%0d",
                     $realtime, seen.value, seen.status, seen.held);
          end
        end else begin
          want = awaited_q.pop_front();
          if (seen !== want) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_MAX) begin
              $display("%0t: mismatch: expected result=%h status=%0d held=%0d batch_end=%b",
                       $realtime, want.value, want.status, want.held, want.batch_end);
              $display("%0t:           actual   result=%h status=%0d held=%0d batch_end=%b",
                       $realtime, seen.value, seen.status, seen.held, seen.batch_end);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        fresh = apply_request(mode_i, site_i, sample_i, last_query_i);
        if (pin_valid) begin
          fresh = pin_want;
        end
        awaited_q.push_back(fresh);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("FAIL sample_log_interpolating_resampler");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] stamp;
    logic [31:0] step;
    int          rand_base;
    int          phase;
    int          next_phase;
    int          n_rec;
    int          n_qry;
    int          n_noise;

    // Directed requests: empty log, extremes, ordering and clamping cases.
    add_row(slir_pkg::MODE_QRY, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0, slir_pkg::ST_EMPTY, 0);
    add_row(MODE_UNUSED, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'h0,
            slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_CLR, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0,
            slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_REC, 32'h0001_0000, 32'h0010_0000, 1'b0, 1'b1, 32'h0,
            slir_pkg::ST_OK, 1);
    // With a single sample every query gives its value.
    add_row(slir_pkg::MODE_QRY, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0010_0000,
            slir_pkg::ST_OK, 1);
    add_row(slir_pkg::MODE_QRY, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 32'h0010_0000,
            slir_pkg::ST_OK, 1);
    add_row(slir_pkg::MODE_REC, 32'h0003_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0,
            slir_pkg::ST_OK, 2);
    add_row(slir_pkg::MODE_QRY, 32'h0002_0000, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_QRY, 32'h0001_0001, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_QRY, 32'h0002_FFFF, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    // A query exactly on a logged time gives that sample.
    add_row(slir_pkg::MODE_QRY, 32'h0003_0000, 32'h0, 1'b1, 1'b1, 32'h7FFF_FFFF,
            slir_pkg::ST_OK, 2);
    // Repeated time stamp.
    add_row(slir_pkg::MODE_REC, 32'h0003_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h0,
            slir_pkg::ST_OK, 3);
    add_row(slir_pkg::MODE_QRY, 32'h0003_0000, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_QRY, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h8000_0000,
            slir_pkg::ST_OK, 3);
    // Out-of-order time stamps are logged anyway.
    add_row(slir_pkg::MODE_REC, 32'h0, 32'h1, 1'b0, 1'b1, 32'h0, slir_pkg::ST_OK, 4);
    add_row(slir_pkg::MODE_QRY, 32'h0002_0000, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_QRY, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_REC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,
            slir_pkg::ST_OK, 5);
    add_row(slir_pkg::MODE_QRY, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_QRY, 32'hFFFF_FFFE, 32'h0, 1'b1, 1'b0, 32'h0, slir_pkg::ST_OK, 0);
    add_row(MODE_UNUSED, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, slir_pkg::ST_OK, 5);
    add_row(slir_pkg::MODE_CLR, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0, slir_pkg::ST_OK, 0);
    add_row(slir_pkg::MODE_QRY, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0,
            slir_pkg::ST_EMPTY, 0);
    add_row(slir_pkg::MODE_REC, 32'h0, 32'h8000_0000, 1'b0, 1'b1, 32'h0, slir_pkg::ST_OK, 1);
    add_row(slir_pkg::MODE_QRY, 32'h0, 32'h0, 1'b1, 1'b1, 32'h8000_0000, slir_pkg::ST_OK, 1);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send(directed_rows[i]);
    end
    wait_drained();

    // Fill the log to the brim, push past it, then query the full log.
    gap_pct = 21;
    send(plain_row(slir_pkg::MODE_CLR, $urandom, $urandom, 1'b0));
    batch_times.delete();
    stamp = $urandom_range(0, 32'h0100_0000);
    for (int i = 0; i < LOG_DEPTH + 3; i++) begin
      send(plain_row(slir_pkg::MODE_REC, stamp, pick_value(), 1'($urandom_range(0, 1))));
      if (i < LOG_DEPTH) begin
        batch_times.push_back(stamp);
      end
      stamp = stamp + (($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 32'h0004_0000));
    end
    for (int i = 0; i < 24; i++) begin
      send(plain_row(slir_pkg::MODE_QRY, pick_query_site(), $urandom, i == 23));
    end
    wait_drained();

    // Random batches: mostly a clear, a run of recorded samples and queries around them,
    // else noise. Before a request the phases idle the sender with odds 0, 46, 0 and 21 %;
    // no phase stalls the receiver, which cannot hold results off.
    rand_base = n_issued;
    phase     = -1;
    while (n_issued - rand_base < RANDOM_ITEMS) begin
      next_phase = ((n_issued - rand_base) * 4) / RANDOM_ITEMS;
      if (next_phase != phase) begin
        phase = next_phase;
        wait_drained();
        case (phase)
          1: gap_pct = 46;
          3: gap_pct = 21;
          default: gap_pct = 0;
        endcase
      end
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 4) != 0) begin
          send(plain_row(slir_pkg::MODE_CLR, $urandom, $urandom, 1'($urandom_range(0, 1))));
          batch_times.delete();
        end
        n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        stamp = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
        for (int i = 0; i < n_rec; i++) begin
          send(plain_row(slir_pkg::MODE_REC, stamp, pick_value(), 1'($urandom_range(0, 1))));
          batch_times.push_back(stamp);
          case ($urandom_range(0, 9))
            0: step = 32'd0;
            1: step = $urandom >> 4;
            default: step = $urandom_range(1, 32'h0002_0000);
          endcase
          stamp = (stamp > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : stamp + step;
        end
        n_qry = $urandom_range(1, 10);
        for (int i = 0; i < n_qry; i++) begin
          send(plain_row(slir_pkg::MODE_QRY, pick_query_site(), $urandom, i == n_qry - 1));
        end
      end else begin
        // Noise: any mode, any fields.
        n_noise = $urandom_range(1, 6);
        for (int i = 0; i < n_noise; i++) begin
          send(plain_row(2'($urandom_range(0, 3)), $urandom, $urandom,
                         1'($urandom_range(0, 1))));
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("PASS sample_log_interpolating_resampler");
    end else begin
      $display("FAIL sample_log_interpolating_resampler");
    end
    $finish;
  end

endmodule
